// File: sv/xxh_pkg.sv
// Shared types, constants and helpers of the XXH64 stream hash.
`default_nettype none
package xxh_pkg;

   typedef logic [63:0] word_type;

   // XXH64 primes
   localparam word_type XXH_PRIME1 = 64'h9E3779B185EBCA87;
   localparam word_type XXH_PRIME2 = 64'hC2B2AE3D27D4EB4F;
   localparam word_type XXH_PRIME3 = 64'h165667B19E3779F9;
   localparam word_type XXH_PRIME4 = 64'h85EBCA77C2B2AE63;
   localparam word_type XXH_PRIME5 = 64'h27D4EB2F165667C5;

   // Datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_BUFFER,
      OP_ROUND_IN,
      OP_RND_ACC,
      OP_RND_WB,
      OP_STRIPE_END,
      OP_SEED5,
      OP_MERGE1,
      OP_MERGE2,
      OP_FOLD_IN,
      OP_ROT31,
      OP_MIXH,
      OP_ADD4,
      OP_ADD_LEN,
      OP_TAIL_WORD,
      OP_MIX27,
      OP_QUAD_IN,
      OP_QUAD_MIX,
      OP_ADD3,
      OP_BYTE_IN,
      OP_BYTE_MIX,
      OP_TAKE,
      OP_AVA1,
      OP_AVA2,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [2:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] pos;
      logic       seen;
      logic       last;
      logic [3:0] cnt;
      logic       mul_busy;
      logic       out_free;
   } dp_status_type;

   // Rotate left by a non-zero amount
   function automatic word_type rotl64(input word_type v, input logic [5:0] s);
      return (v << s) | (v >> (7'd64 - {1'b0, s}));
   endfunction

endpackage
`default_nettype wire

// File: sv/xxh_req_if.sv
// Input channel: message words with byte count and last marker.
`default_nettype none
interface xxh_req_if;
   import xxh_pkg::*;

   logic       valid;
   logic       ready;
   word_type   data_word;
   logic [3:0] byte_count;
   logic       last_word;

   modport source (output valid, data_word, byte_count, last_word, input ready);
   modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface
`default_nettype wire

// File: sv/xxh_rsp_if.sv
// Result channel: one 64-bit digest per message.
`default_nettype none
interface xxh_rsp_if;
   import xxh_pkg::*;

   logic     valid;
   logic     ready;
   word_type hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink (input valid, hash_value, output ready);
endinterface
`default_nettype wire

// File: sv/xxh_mul.sv
// Shared 64x64 modulo 2^64 multiplier built from one 32x32 multiplier, summing low*low and the two cross terms.
`default_nettype none
module xxh_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  xxh_pkg::word_type op_a,
   input  xxh_pkg::word_type op_b,
   output logic              busy,
   output xxh_pkg::word_type product
);
   import xxh_pkg::*;

   word_type    a_ff;
   word_type    b_ff;
   word_type    p_ff;
   word_type    p_in;
   logic [1:0]  step_ff;
   logic        busy_ff;
   logic [31:0] mul_x;
   logic [31:0] mul_y;
   logic [63:0] mul_m;

   // Partial product select: low*low, then the two cross terms
   always_comb begin
      case (step_ff)
         2'd0: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[31:0];
         end
         2'd1: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[63:32];
         end
         default: begin
            mul_x = a_ff[63:32];
            mul_y = b_ff[31:0];
         end
      endcase
      mul_m = {32'b0, mul_x} * {32'b0, mul_y};
      p_in  = (step_ff == 2'd0) ? mul_m : p_ff + {mul_m[31:0], 32'b0};
   end

   // Step sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 2'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= 2'd0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 2'd1;
         if (step_ff == 2'd2) busy_ff <= 1'b0;
      end
   end

   // Operands and accumulated product
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      if (busy_ff) p_ff <= p_in;
   end

   assign busy    = busy_ff;
   assign product = p_ff;

   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("multiplier started while busy");
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && step_ff == 2'd2) |=> !busy_ff)
      else $error("multiplier overran three steps");
   assert property (@(posedge clock) disable iff (reset) start |=> busy_ff && step_ff == 2'd0)
      else $error("multiplier did not start");

endmodule
`default_nettype wire

// File: sv/xxh_datapath.sv
// Datapath: lanes, stripe buffer, length, hash accumulator and output register.
`default_nettype none
module xxh_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  xxh_pkg::dp_cmd_type    cmd,
   output xxh_pkg::dp_status_type status,
   input  logic                   csr_we,
   input  xxh_pkg::word_type      csr_data,
   input  xxh_pkg::word_type      in_word,
   input  logic [3:0]             in_count,
   input  logic                   in_last,
   output logic                   rsp_valid,
   output xxh_pkg::word_type      rsp_hash,
   input  logic                   rsp_ready
);
   import xxh_pkg::*;

   word_type   seed_ff;
   word_type   msg_seed_ff;
   word_type   lane_ff [4];
   word_type   buf_ff [3];
   word_type   len_ff;
   word_type   len_in;
   word_type   word_ff;
   word_type   h_ff;
   word_type   x_ff;
   word_type   hash_ff;
   logic [3:0] cnt_ff;
   logic [3:0] cnt_eff;
   logic [1:0] pos_ff;
   logic       last_ff;
   logic       seen_ff;
   logic       in_msg_ff;
   logic       rsp_valid_ff;

   word_type   buf_rd;
   word_type   lane_rd;
   word_type   mix_x;
   logic [7:0] byte_rd;
   logic       mul_start;
   word_type   mul_a;
   word_type   mul_b;
   logic       mul_busy;
   word_type   mul_p;

   xxh_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .busy    (mul_busy),
      .product (mul_p)
   );

   // Effective byte count and running length
   assign cnt_eff = (!in_last || in_count > 4'd8) ? 4'd8 : in_count;
   assign len_in  = (in_msg_ff ? len_ff : '0) + {60'b0, cnt_eff};

   // Round input: buffered word, or the current word for the fourth lane
   always_comb begin
      case (cmd.idx[1:0])
         2'd0:    buf_rd = buf_ff[0];
         2'd1:    buf_rd = buf_ff[1];
         2'd2:    buf_rd = buf_ff[2];
         default: buf_rd = word_ff;
      endcase
   end

   assign lane_rd = lane_ff[cmd.idx[1:0]];
   assign mix_x   = h_ff ^ mul_p;
   assign byte_rd = word_ff[{cmd.idx, 3'b000} +: 8];

   // Multiplier operand select
   always_comb begin
      mul_start = 1'b1;
      mul_a     = '0;
      mul_b     = '0;
      case (cmd.op)
         OP_ROUND_IN: begin
            mul_a = buf_rd;
            mul_b = XXH_PRIME2;
         end
         OP_RND_ACC: begin
            mul_a = rotl64(lane_rd + mul_p, 6'd31);
            mul_b = XXH_PRIME1;
         end
         OP_FOLD_IN: begin
            mul_a = lane_rd;
            mul_b = XXH_PRIME2;
         end
         OP_TAIL_WORD: begin
            mul_a = word_ff;
            mul_b = XXH_PRIME2;
         end
         OP_ROT31: begin
            mul_a = rotl64(mul_p, 6'd31);
            mul_b = XXH_PRIME1;
         end
         OP_MIXH: begin
            mul_a = mix_x;
            mul_b = XXH_PRIME1;
         end
         OP_MIX27: begin
            mul_a = rotl64(mix_x, 6'd27);
            mul_b = XXH_PRIME1;
         end
         OP_QUAD_IN: begin
            mul_a = {32'b0, word_ff[31:0]};
            mul_b = XXH_PRIME1;
         end
         OP_QUAD_MIX: begin
            mul_a = rotl64(mix_x, 6'd23);
            mul_b = XXH_PRIME2;
         end
         OP_BYTE_IN: begin
            mul_a = {56'b0, byte_rd};
            mul_b = XXH_PRIME5;
         end
         OP_BYTE_MIX: begin
            mul_a = rotl64(mix_x, 6'd11);
            mul_b = XXH_PRIME1;
         end
         OP_AVA1: begin
            mul_a = h_ff ^ (h_ff >> 33);
            mul_b = XXH_PRIME2;
         end
         OP_AVA2: begin
            mul_a = mul_p ^ (mul_p >> 29);
            mul_b = XXH_PRIME3;
         end
         default: mul_start = 1'b0;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         in_msg_ff    <= 1'b0;
         pos_ff       <= 2'd0;
         seen_ff      <= 1'b0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) seed_ff <= csr_data;
         if (rsp_ready && cmd.op != OP_EMIT) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            OP_CAPTURE: begin
               in_msg_ff <= 1'b1;
               len_ff    <= len_in;
               if (!in_msg_ff) begin
                  pos_ff  <= 2'd0;
                  seen_ff <= 1'b0;
               end
            end
            OP_BUFFER: pos_ff <= pos_ff + 2'd1;
            OP_STRIPE_END: begin
               pos_ff  <= 2'd0;
               seen_ff <= 1'b1;
            end
            OP_EMIT: begin
               in_msg_ff    <= 1'b0;
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            word_ff <= in_word;
            cnt_ff  <= cnt_eff;
            last_ff <= in_last;
            if (!in_msg_ff) begin
               msg_seed_ff <= seed_ff;
               lane_ff[0]  <= seed_ff + XXH_PRIME1 + XXH_PRIME2;
               lane_ff[1]  <= seed_ff + XXH_PRIME2;
               lane_ff[2]  <= seed_ff;
               lane_ff[3]  <= seed_ff - XXH_PRIME1;
            end
         end
         OP_BUFFER: begin
            case (pos_ff)
               2'd0:    buf_ff[0] <= word_ff;
               2'd1:    buf_ff[1] <= word_ff;
               2'd2:    buf_ff[2] <= word_ff;
               default: ;
            endcase
         end
         OP_RND_WB:     lane_ff[cmd.idx[1:0]] <= mul_p;
         OP_STRIPE_END: cnt_ff <= 4'd0;
         OP_SEED5:      h_ff <= msg_seed_ff + XXH_PRIME5;
         OP_MERGE1: begin
            h_ff <= rotl64(lane_ff[0], 6'd1) + rotl64(lane_ff[1], 6'd7);
            x_ff <= rotl64(lane_ff[2], 6'd12) + rotl64(lane_ff[3], 6'd18);
         end
         OP_MERGE2:  h_ff <= h_ff + x_ff;
         OP_ADD_LEN: h_ff <= h_ff + len_ff;
         OP_ADD4:    h_ff <= mul_p + XXH_PRIME4;
         OP_ADD3:    h_ff <= mul_p + XXH_PRIME3;
         OP_TAKE:    h_ff <= mul_p;
         OP_EMIT:    hash_ff <= mul_p ^ (mul_p >> 32);
         default: ;
      endcase
   end

   assign status.pos      = pos_ff;
   assign status.seen     = seen_ff;
   assign status.last     = last_ff;
   assign status.cnt      = cnt_ff;
   assign status.mul_busy = mul_busy;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hash        = hash_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_BUFFER |-> pos_ff != 2'd3)
      else $error("stripe buffer written while full");
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |-> (!rsp_valid_ff || rsp_ready))
      else $error("digest overwrote an untaken result");
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |=> rsp_valid_ff && !in_msg_ff)
      else $error("message not closed after digest");

endmodule
`default_nettype wire

// File: sv/xxh_ctrl.sv
// Controller: sequences word intake, stripe rounds and finalisation.
`default_nettype none
module xxh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  xxh_pkg::dp_status_type status,
   output xxh_pkg::dp_cmd_type    cmd
);
   import xxh_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DECIDE, S_BUFFER,
      S_RND_IN, S_RND_ACC, S_RND_WB, S_STRIPE_END,
      S_FIN_START, S_SEED5, S_MERGE1, S_MERGE2,
      S_FOLD_IN, S_FOLD_ROT, S_FOLD_MIX, S_FOLD_ADD,
      S_ADD_LEN, S_TAIL_SEL, S_TAIL_IN, S_TAIL_ROT, S_TAIL_MIX, S_TAIL_ADD,
      S_QUAD_IN, S_QUAD_MIX, S_QUAD_ADD,
      S_BYTE_SEL, S_BYTE_IN, S_BYTE_MIX, S_BYTE_TAKE,
      S_AVA1, S_AVA2, S_EMIT, S_WAIT
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   state_type  ret_ff;
   state_type  ret_in;
   logic [2:0] idx_ff;
   logic [2:0] idx_in;
   dp_op_type  op;

   // Next state and command
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      idx_in   = idx_ff;
      op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_CAPTURE;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            idx_in = 3'd0;
            if (status.pos == 2'd3 && status.cnt == 4'd8) state_in = S_RND_IN;
            else if (!status.last)                        state_in = S_BUFFER;
            else                                          state_in = S_FIN_START;
         end
         S_BUFFER: begin
            op       = OP_BUFFER;
            state_in = S_IDLE;
         end
         // Lane rounds over a full stripe
         S_RND_IN: begin
            op       = OP_ROUND_IN;
            ret_in   = S_RND_ACC;
            state_in = S_WAIT;
         end
         S_RND_ACC: begin
            op       = OP_RND_ACC;
            ret_in   = S_RND_WB;
            state_in = S_WAIT;
         end
         S_RND_WB: begin
            op = OP_RND_WB;
            if (idx_ff == 3'd3) begin
               state_in = S_STRIPE_END;
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = S_RND_IN;
            end
         end
         S_STRIPE_END: begin
            op       = OP_STRIPE_END;
            state_in = status.last ? S_FIN_START : S_IDLE;
         end
         // Accumulator start: merged lanes or seed
         S_FIN_START: begin
            idx_in   = 3'd0;
            state_in = status.seen ? S_MERGE1 : S_SEED5;
         end
         S_SEED5: begin
            op       = OP_SEED5;
            state_in = S_ADD_LEN;
         end
         S_MERGE1: begin
            op       = OP_MERGE1;
            state_in = S_MERGE2;
         end
         S_MERGE2: begin
            op       = OP_MERGE2;
            state_in = S_FOLD_IN;
         end
         S_FOLD_IN: begin
            op       = OP_FOLD_IN;
            ret_in   = S_FOLD_ROT;
            state_in = S_WAIT;
         end
         S_FOLD_ROT: begin
            op       = OP_ROT31;
            ret_in   = S_FOLD_MIX;
            state_in = S_WAIT;
         end
         S_FOLD_MIX: begin
            op       = OP_MIXH;
            ret_in   = S_FOLD_ADD;
            state_in = S_WAIT;
         end
         S_FOLD_ADD: begin
            op = OP_ADD4;
            if (idx_ff == 3'd3) begin
               state_in = S_ADD_LEN;
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = S_FOLD_IN;
            end
         end
         S_ADD_LEN: begin
            op       = OP_ADD_LEN;
            idx_in   = 3'd0;
            state_in = S_TAIL_SEL;
         end
         // Tail: buffered words, full last word, 4-byte piece, single bytes
         S_TAIL_SEL: begin
            if (idx_ff < {1'b0, status.pos} || status.cnt == 4'd8) begin
               state_in = S_TAIL_IN;
            end else if (status.cnt >= 4'd4) begin
               state_in = S_QUAD_IN;
            end else begin
               idx_in   = 3'd0;
               state_in = S_BYTE_SEL;
            end
         end
         S_TAIL_IN: begin
            op       = (idx_ff < {1'b0, status.pos}) ? OP_ROUND_IN : OP_TAIL_WORD;
            ret_in   = S_TAIL_ROT;
            state_in = S_WAIT;
         end
         S_TAIL_ROT: begin
            op       = OP_ROT31;
            ret_in   = S_TAIL_MIX;
            state_in = S_WAIT;
         end
         S_TAIL_MIX: begin
            op       = OP_MIX27;
            ret_in   = S_TAIL_ADD;
            state_in = S_WAIT;
         end
         S_TAIL_ADD: begin
            op = OP_ADD4;
            if (idx_ff < {1'b0, status.pos}) begin
               idx_in   = idx_ff + 3'd1;
               state_in = S_TAIL_SEL;
            end else begin
               state_in = S_AVA1;
            end
         end
         S_QUAD_IN: begin
            op       = OP_QUAD_IN;
            ret_in   = S_QUAD_MIX;
            state_in = S_WAIT;
         end
         S_QUAD_MIX: begin
            op       = OP_QUAD_MIX;
            ret_in   = S_QUAD_ADD;
            state_in = S_WAIT;
         end
         S_QUAD_ADD: begin
            op       = OP_ADD3;
            idx_in   = 3'd4;
            state_in = S_BYTE_SEL;
         end
         S_BYTE_SEL: begin
            state_in = ({1'b0, idx_ff} < status.cnt) ? S_BYTE_IN : S_AVA1;
         end
         S_BYTE_IN: begin
            op       = OP_BYTE_IN;
            ret_in   = S_BYTE_MIX;
            state_in = S_WAIT;
         end
         S_BYTE_MIX: begin
            op       = OP_BYTE_MIX;
            ret_in   = S_BYTE_TAKE;
            state_in = S_WAIT;
         end
         S_BYTE_TAKE: begin
            op       = OP_TAKE;
            idx_in   = idx_ff + 3'd1;
            state_in = S_BYTE_SEL;
         end
         // Final avalanche
         S_AVA1: begin
            op       = OP_AVA1;
            ret_in   = S_AVA2;
            state_in = S_WAIT;
         end
         S_AVA2: begin
            op       = OP_AVA2;
            ret_in   = S_EMIT;
            state_in = S_WAIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               op       = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         S_WAIT: begin
            if (!status.mul_busy) state_in = ret_ff;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         idx_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign cmd.op    = op;
   assign cmd.idx   = idx_ff;

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WAIT |-> ret_ff != S_WAIT && ret_ff != S_IDLE)
      else $error("wait state without a return point");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT && status.mul_busy) |=> state_ff == S_WAIT)
      else $error("left wait while multiplier busy");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STRIPE_END) |-> idx_ff == 3'd3)
      else $error("stripe closed before all lanes updated");

endmodule
`default_nettype wire

// File: sv/xxh64_stream_hash.sv
// Top level of the XXH64 stream hash: controller, datapath and channel wiring.
// A new word is taken only in idle, once the previous one is buffered or has completed a
//   32-byte stripe (four lane rounds, two 64-bit products each).
// The time from the last word to the digest depends on the tail length
//   and whether lanes are merged, plus any wait for the previous digest to be taken.
// Every 64-bit product is computed on the one shared 32x32 multiplier, which paces all.
// Reset (synchronous, active high) clears the seed to zero and closes any open message.
`default_nettype none
module xxh64_stream_hash (
   input  logic              clock,
   input  logic              reset,
   xxh_req_if.sink           req_port,
   xxh_rsp_if.source         rsp_port,
   input  logic              csr_write_enable,
   input  xxh_pkg::word_type csr_write_data
);
   import xxh_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   xxh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   xxh_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_write_enable),
      .csr_data  (csr_write_data),
      .in_word   (req_port.data_word),
      .in_count  (req_port.byte_count),
      .in_last   (req_port.last_word),
      .rsp_valid (rsp_port.valid),
      .rsp_hash  (rsp_port.hash_value),
      .rsp_ready (rsp_port.ready)
   );

endmodule
`default_nettype wire
